### hdl/itg_pkg.sv
// ============================================================================
// itg_pkg
// Shared types and constants for the isochronic tone generator core.
// ============================================================================
package itg_pkg;

  // Default sizing of the sine table and the phase accumulator.
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;

  // Port widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 8;
  localparam int SAMPLE_W    = 16;
  localparam int OUT_DATA_W  = 2 * SAMPLE_W;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_LEN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AUDIBLE    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_LEN   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_RECIP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_GAIN  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_GAIN = 3'd7;

  // Configuration reset values.
  localparam logic [31:0] PHASE_INC_RST  = 32'd17895697;
  localparam logic [23:0] CYCLE_LEN_RST  = 24'd12000;
  localparam logic [23:0] AUDIBLE_RST    = 24'd10200;
  localparam logic [22:0] RAMP_LEN_RST   = 23'd2040;
  localparam logic [31:0] RAMP_RECIP_RST = 32'd1052688;
  localparam logic [15:0] AMPLITUDE_RST  = 16'd16384;
  localparam logic [15:0] LEFT_GAIN_RST  = 16'd32768;
  localparam logic [15:0] RIGHT_GAIN_RST = 16'd32768;

  // Fixed-point constants of the sine series and the envelope.
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] ENV_FULL_Q15 = 16'h8000;

  // Sequencer states: each step uses the shared multiplier at most once.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROM,
    ST_RAMP,
    ST_ZONE,
    ST_ENV,
    ST_SAT,
    ST_GAIN_L,
    ST_GAIN_R,
    ST_PROD_L,
    ST_PROD_R,
    ST_OUT
  } itg_state_t;

  // Envelope region of the current cycle position.
  typedef enum logic [1:0] {
    ZN_SILENT,
    ZN_FULL,
    ZN_SLOPE
  } itg_zone_t;

endpackage

### hdl/isochronic_tone_generator_core.sv
// ============================================================================
// isochronic_tone_generator_core
// Stereo tone generator: phase accumulator, quarter-wave sine ROM and a
// trapezoid beat envelope, scaled by amplitude and per-channel gains.
// ============================================================================
// Each sample steps through the sequencer states ST_ROM to ST_OUT and then
// waits in ST_OUT until the output register is free; the six products run
// one after another through the single shared 32x32 multiplier.
// in_tready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous): configuration registers return to their
// defaults, phase and cycle position clear, the output register empties.
module isochronic_tone_generator_core
  import itg_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [0] restart, [7:1] zero
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata   // [15:0] left_sample, [31:16] right_sample
);

  localparam int ROM_SIZE = 1 << SINE_TABLE_BITS;
  localparam int IDX_W    = SINE_TABLE_BITS + 2;
  localparam int PSUM_W   = (PHASE_BITS > 32) ? PHASE_BITS : 32;

  typedef logic [14:0] rom_t [ROM_SIZE];

  // One ROM entry from the Q30 sine series.
  function automatic logic [14:0] rom_entry(int unsigned k);
    logic [63:0] frac;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] s;
    frac = 64'(2 * k + 1) << (29 - SINE_TABLE_BITS);
    t    = (HALF_PI_Q30 * frac) >> 30;
    t2   = (t * t) >> 30;
    s    = Q30_ONE;
    s    = Q30_ONE - ((t2 * s) >> 30) / 110;
    s    = Q30_ONE - ((t2 * s) >> 30) / 72;
    s    = Q30_ONE - ((t2 * s) >> 30) / 42;
    s    = Q30_ONE - ((t2 * s) >> 30) / 20;
    s    = Q30_ONE - ((t2 * s) >> 30) / 6;
    s    = (t * s) >> 30;
    return 15'((s * 64'd32767 + (Q30_ONE >> 1)) >> 30);
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k < ROM_SIZE; k++) begin
      rom[k] = rom_entry(k);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Round, apply the sign and saturate one channel product.
  function automatic logic [SAMPLE_W-1:0] finish_sample(logic [61:0] prod, logic neg);
    logic [62:0] rnd;
    logic [17:0] mag;
    logic [SAMPLE_W-1:0] res;
    rnd = {1'b0, prod} + (63'd1 << 44);
    mag = rnd[62:45];
    if (neg) begin
      res = (mag > 18'd32768) ? 16'h8000 : 16'(18'd0 - mag);
    end else begin
      res = (mag > 18'd32767) ? 16'h7FFF : mag[15:0];
    end
    return res;
  endfunction

  // Configuration registers.
  logic [31:0] phase_inc_r;
  logic [23:0] cycle_len_r;
  logic [23:0] audible_r;
  logic [22:0] ramp_len_r;
  logic [31:0] ramp_recip_r;
  logic [15:0] amplitude_r;
  logic [15:0] left_gain_r;
  logic [15:0] right_gain_r;

  // Generator state.
  logic [PHASE_BITS-1:0] phase_r;
  logic [23:0]           pos_r;
  itg_state_t            state_r, state_nxt;

  // Per-sample working registers.
  logic [14:0]         rom_q_r;
  logic                neg_r;
  logic [23:0]         aud_r;
  logic [22:0]         ramp_r;
  logic [30:0]         mag_amp_r;
  itg_zone_t           zone_r;
  logic [23:0]         slope_t_r;
  logic [55:0]         env_prod_r;
  logic [15:0]         env_r;
  logic [30:0]         env_gl_r;
  logic [30:0]         env_gr_r;
  logic [61:0]         prod_l_r;
  logic [61:0]         prod_r_r;

  // Output register.
  logic                out_tvalid_r;
  logic [SAMPLE_W-1:0] out_left_r;
  logic [SAMPLE_W-1:0] out_right_r;

  logic                in_fire;
  logic                out_free;
  logic [IDX_W-1:0]    phase_idx;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic [PSUM_W-1:0]   phase_sum;
  logic [23:0]         pos_inc;
  logic [23:0]         pos_adv;
  logic [23:0]         fall_start;
  logic                env_over;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         mul_p;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_right_r, out_left_r};

  // Quadrant decode of the phase: mirror in odd quadrants.
  assign phase_idx = phase_r[PHASE_BITS-1 -: IDX_W];
  assign rom_addr  = phase_idx[SINE_TABLE_BITS] ? ~phase_idx[SINE_TABLE_BITS-1:0]
                                                : phase_idx[SINE_TABLE_BITS-1:0];

  // Phase and cycle position advance after each sample.
  assign phase_sum = PSUM_W'(phase_r) + PSUM_W'(phase_inc_r);
  assign pos_inc   = pos_r + 24'd1;
  assign pos_adv   = ((cycle_len_r == 24'd0) || (pos_inc >= cycle_len_r)) ? 24'd0 : pos_inc;

  assign fall_start = aud_r - {1'b0, ramp_r};
  assign env_over   = (|env_prod_r[55:32]) || (env_prod_r[31] && (|env_prod_r[30:0]));

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      ST_RAMP: begin
        mul_a = {17'd0, rom_q_r};
        mul_b = {16'd0, amplitude_r};
      end
      ST_ENV: begin
        mul_a = {8'd0, slope_t_r};
        mul_b = ramp_recip_r;
      end
      ST_GAIN_L: begin
        mul_a = {16'd0, env_r};
        mul_b = {16'd0, left_gain_r};
      end
      ST_GAIN_R: begin
        mul_a = {16'd0, env_r};
        mul_b = {16'd0, right_gain_r};
      end
      ST_PROD_L: begin
        mul_a = {1'b0, mag_amp_r};
        mul_b = {1'b0, env_gl_r};
      end
      ST_PROD_R: begin
        mul_a = {1'b0, mag_amp_r};
        mul_b = {1'b0, env_gr_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) begin
                   state_nxt = ST_ROM;
                 end
      ST_ROM:    state_nxt = ST_RAMP;
      ST_RAMP:   state_nxt = ST_ZONE;
      ST_ZONE:   state_nxt = ST_ENV;
      ST_ENV:    state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_GAIN_L;
      ST_GAIN_L: state_nxt = ST_GAIN_R;
      ST_GAIN_R: state_nxt = ST_PROD_L;
      ST_PROD_L: state_nxt = ST_PROD_R;
      ST_PROD_R: state_nxt = ST_OUT;
      ST_OUT:    if (out_free) begin
                   state_nxt = ST_IDLE;
                 end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r  <= PHASE_INC_RST;
      cycle_len_r  <= CYCLE_LEN_RST;
      audible_r    <= AUDIBLE_RST;
      ramp_len_r   <= RAMP_LEN_RST;
      ramp_recip_r <= RAMP_RECIP_RST;
      amplitude_r  <= AMPLITUDE_RST;
      left_gain_r  <= LEFT_GAIN_RST;
      right_gain_r <= RIGHT_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_INC:  phase_inc_r  <= cfg_data;
        REG_CYCLE_LEN:  cycle_len_r  <= cfg_data[23:0];
        REG_AUDIBLE:    audible_r    <= cfg_data[23:0];
        REG_RAMP_LEN:   ramp_len_r   <= cfg_data[22:0];
        REG_RAMP_RECIP: ramp_recip_r <= cfg_data;
        REG_AMPLITUDE:  amplitude_r  <= cfg_data[15:0];
        REG_LEFT_GAIN:  left_gain_r  <= cfg_data[15:0];
        REG_RIGHT_GAIN: right_gain_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Phase and cycle position: restart clears them when the transaction
  // is taken, the finished sample advances them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      pos_r   <= 24'd0;
    end else if (in_fire && in_tdata[0]) begin
      phase_r <= '0;
      pos_r   <= 24'd0;
    end else if ((state_r == ST_OUT) && out_free) begin
      phase_r <= phase_sum[PHASE_BITS-1:0];
      pos_r   <= pos_adv;
    end
  end

  // Datapath steps of one sample.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_ROM: begin
        rom_q_r <= SINE_ROM[rom_addr];
        neg_r   <= phase_idx[SINE_TABLE_BITS+1];
        aud_r   <= (audible_r < cycle_len_r) ? audible_r : cycle_len_r;
      end
      ST_RAMP: begin
        ramp_r    <= (ramp_len_r < aud_r[23:1]) ? ramp_len_r : aud_r[23:1];
        mag_amp_r <= mul_p[30:0];
      end
      ST_ZONE: begin
        // Classify the position within the trapezoid. The slope distance
        // counts from the start on the rise and back from the end on the fall.
        slope_t_r <= (pos_r < {1'b0, ramp_r}) ? pos_r : aud_r - pos_r;
        if (pos_r >= aud_r) begin
          zone_r <= ZN_SILENT;
        end else if (ramp_r == 23'd0) begin
          zone_r <= ZN_FULL;
        end else if (pos_r < {1'b0, ramp_r}) begin
          zone_r <= ZN_SLOPE;
        end else if (pos_r >= fall_start) begin
          zone_r <= ZN_SLOPE;
        end else begin
          zone_r <= ZN_FULL;
        end
      end
      ST_ENV: begin
        env_prod_r <= mul_p[55:0];
      end
      ST_SAT: begin
        case (zone_r)
          ZN_SILENT: env_r <= 16'd0;
          ZN_FULL:   env_r <= ENV_FULL_Q15;
          ZN_SLOPE:  env_r <= env_over ? ENV_FULL_Q15 : env_prod_r[31:16];
          default:   env_r <= 16'd0;
        endcase
      end
      ST_GAIN_L: begin
        env_gl_r <= mul_p[30:0];
      end
      ST_GAIN_R: begin
        env_gr_r <= mul_p[30:0];
      end
      ST_PROD_L: begin
        prod_l_r <= mul_p[61:0];
      end
      ST_PROD_R: begin
        prod_r_r <= mul_p[61:0];
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a finished sample until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      out_left_r  <= finish_sample(prod_l_r, neg_r);
      out_right_r <= finish_sample(prod_r_r, neg_r);
    end
  end

endmodule

### hdl/itg_checker.sv
// ============================================================================
// itg_checker
// Port-level checks of the tone generator core, bound to its top level.
// ============================================================================
module itg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The sequencer is busy after taking an input transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while a sample is in progress");

  // A new result appears only as the sequencer returns to idle.
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result appeared while the sequencer was busy");

endmodule

bind isochronic_tone_generator_core itg_checker u_itg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### dv/tone_scoreboard_pkg.sv
// ============================================================================
// tone_scoreboard_pkg
// Bit-accurate prediction of the tone generator's stereo samples and an
// in-order check of the result stream against the predicted samples.
// ============================================================================
package tone_scoreboard_pkg;
  import itg_pkg::*;

  localparam int ROM_BITS   = SINE_TABLE_BITS_DEF;
  localparam int ROM_DEPTH  = 1 << ROM_BITS;
  localparam int PHASE_W    = PHASE_BITS_DEF;
  localparam int ADDR_SHIFT = PHASE_W - ROM_BITS - 2;

  // One stereo sample as it leaves the block.
  typedef struct packed {
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } stereo_t;

  class tone_scoreboard;
    // Shadow copy of the configuration registers.
    logic [31:0] phase_inc;
    logic [23:0] cycle_len;
    logic [23:0] audible_len;
    logic [22:0] ramp_len;
    logic [31:0] ramp_recip;
    logic [15:0] amplitude;
    logic [15:0] gain_left;
    logic [15:0] gain_right;

    // Shadow copy of the oscillator and beat counter.
    logic [PHASE_W-1:0] phase;
    logic [23:0]        position;

    logic [15:0] sine_rom [ROM_DEPTH];
    int unsigned series_div [5] = '{110, 72, 42, 20, 6};
    stereo_t     samples_due [$];
    int          errors;

    function new();
      phase_inc   = PHASE_INC_RST;
      cycle_len   = CYCLE_LEN_RST;
      audible_len = AUDIBLE_RST;
      ramp_len    = RAMP_LEN_RST;
      ramp_recip  = RAMP_RECIP_RST;
      amplitude   = AMPLITUDE_RST;
      gain_left   = LEFT_GAIN_RST;
      gain_right  = RIGHT_GAIN_RST;
      phase       = '0;
      position    = '0;
      errors      = 0;
      for (int k = 0; k < ROM_DEPTH; k++) begin
        sine_rom[k] = quarter_sine(k);
      end
    endfunction

    // Quarter-wave entry from the Q30 Taylor series, rounded to 15 bits.
    function logic [15:0] quarter_sine(int k);
      logic [63:0] frac;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] s;
      logic [63:0] q;
      frac = 64'(2 * k + 1) << (29 - ROM_BITS);
      t    = (HALF_PI_Q30 * frac) >> 30;
      t2   = (t * t) >> 30;
      s    = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
        s = Q30_ONE - ((t2 * s) >> 30) / 64'(series_div[i]);
      end
      s = (t * s) >> 30;
      q = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      return q[15:0];
    endfunction

    // Trapezoid beat gate in Q15 for one cycle position.
    function logic [15:0] beat_gate(logic [23:0] t);
      logic [23:0] aud;
      logic [23:0] ramp;
      logic [63:0] e;
      if (cycle_len == 24'd0) return 16'd0;
      aud = (audible_len < cycle_len) ? audible_len : cycle_len;
      if (t >= aud) return 16'd0;
      ramp = ({1'b0, ramp_len} < (aud >> 1)) ? {1'b0, ramp_len} : (aud >> 1);
      if (ramp == 24'd0) return ENV_FULL_Q15;
      if (t < ramp) begin
        e = 64'(t) * 64'(ramp_recip);
      end else if (t >= aud - ramp) begin
        e = 64'(aud - t) * 64'(ramp_recip);
      end else begin
        e = 64'd1 << 31;
      end
      if (e > (64'd1 << 31)) e = 64'd1 << 31;
      e = e >> 16;
      return e[15:0];
    endfunction

    // Channel gain, round half away from zero, saturate to signed 16 bits.
    function logic [15:0] apply_gain(logic [63:0] base, bit negative, logic [15:0] gain);
      logic [63:0] r;
      logic [63:0] n;
      r = (base * 64'(gain) + (64'd1 << 44)) >> 45;
      if (negative) begin
        if (r > 64'd32768) return 16'h8000;
        n = 64'd0 - r;
        return n[15:0];
      end
      if (r > 64'd32767) return 16'h7fff;
      return r[15:0];
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_PHASE_INC:  phase_inc   = value;
        REG_CYCLE_LEN:  cycle_len   = value[23:0];
        REG_AUDIBLE:    audible_len = value[23:0];
        REG_RAMP_LEN:   ramp_len    = value[22:0];
        REG_RAMP_RECIP: ramp_recip  = value;
        REG_AMPLITUDE:  amplitude   = value[15:0];
        REG_LEFT_GAIN:  gain_left   = value[15:0];
        REG_RIGHT_GAIN: gain_right  = value[15:0];
        default: ;
      endcase
    endfunction

    // Form the sample caused by one accepted input, then advance the state.
    function void next_sample(bit restart);
      logic [ROM_BITS+1:0] addr;
      logic [1:0]          quadrant;
      logic [ROM_BITS-1:0] k;
      logic [15:0]         mag;
      bit                  negative;
      logic [63:0]         base;
      stereo_t             s;
      if (restart) begin
        phase    = '0;
        position = '0;
      end
      addr     = (ROM_BITS+2)'(phase >> ADDR_SHIFT);
      quadrant = addr[ROM_BITS+1:ROM_BITS];
      k        = addr[ROM_BITS-1:0];
      if (quadrant[0]) k = ~k;
      mag      = sine_rom[k];
      negative = quadrant[1] && (mag != 16'd0);
      base     = 64'(mag) * 64'(amplitude) * 64'(beat_gate(position));
      s.left   = apply_gain(base, negative, gain_left);
      s.right  = apply_gain(base, negative, gain_right);
      samples_due.push_back(s);

      phase = phase + phase_inc;
      if (cycle_len == 24'd0) begin
        position = '0;
      end else begin
        position = position + 24'd1;
        if (position >= cycle_len) position = '0;
      end
    endfunction

    function void report(string what, logic [15:0] due, logic [15:0] got);
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, what, due, got);
    endfunction

    function void check_sample(logic [OUT_DATA_W-1:0] tdata);
      stereo_t due;
      stereo_t got;
      got = tdata;
      if (samples_due.size() == 0) begin
        errors++;
        $display("%0t unexpected sample: expected none actual %h", $time, tdata);
        return;
      end
      due = samples_due.pop_front();
      if (got.left !== due.left) report("left_sample", due.left, got.left);
      if (got.right !== due.right) report("right_sample", due.right, got.right);
    endfunction

    function int pending();
      return samples_due.size();
    endfunction
  endclass

endpackage

### dv/tb_top.sv
// ============================================================================
// tb_top
// Drives the tone generator with bursts of sample requests under a series of
// register settings, and checks every stereo sample against a prediction.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itg_pkg::*;
  import tone_scoreboard_pkg::*;

  localparam int TARGET_ITEMS = 1550;
  localparam int IDLE_PCT     = 12;
  localparam int DRAIN_CYCLES = 20;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;   // [0] restart, [7:1] zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;         // [15:0] left_sample, [31:16] right_sample

  tone_scoreboard sb = new();
  bit             quiet = 1'b0;
  int             items_sent = 0;

  isochronic_tone_generator_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Register writes and accepted inputs update the prediction.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.next_sample(in_tdata[0]);
  end

  // Every output transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sample(out_tdata);
  end

  // Offer one sample request, with random idle cycles ahead of it.
  task automatic drive_sample(input bit restart);
    while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no second update.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_all(input logic [31:0] pinc, input logic [23:0] clen,
                             input logic [23:0] alen, input logic [22:0] rlen,
                             input logic [31:0] rrec, input logic [15:0] amp,
                             input logic [15:0] gl, input logic [15:0] gr);
    write_reg(REG_PHASE_INC, pinc);
    write_reg(REG_CYCLE_LEN, 32'(clen));
    write_reg(REG_AUDIBLE, 32'(alen));
    write_reg(REG_RAMP_LEN, 32'(rlen));
    write_reg(REG_RAMP_RECIP, rrec);
    write_reg(REG_AMPLITUDE, 32'(amp));
    write_reg(REG_LEFT_GAIN, 32'(gl));
    write_reg(REG_RIGHT_GAIN, 32'(gr));
    cfg_valid <= 1'b0;
  endtask

  // Wait until every predicted sample has come out.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A burst of requests; the first may restart, later ones rarely do.
  task automatic run_burst(input int n, input bit first_restart, input int restart_pct);
    for (int i = 0; i < n; i++) begin
      drive_sample(i == 0 ? first_restart : ($urandom_range(99) < restart_pct));
    end
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  function automatic logic [15:0] pick_q15();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd32768;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  // A random register setting biased toward short beat cycles.
  task automatic randomize_config();
    logic [31:0] pinc;
    logic [23:0] clen;
    logic [23:0] alen;
    logic [23:0] aud;
    logic [22:0] rlen;
    logic [31:0] rrec;
    case ($urandom_range(9))
      0, 1, 2: pinc = $urandom;
      3, 4:    pinc = $urandom_range(32'h0100_0000);
      5, 6:    pinc = ($urandom_range(3) << 30) + $urandom_range(64) - 32;
      7:       pinc = 32'd0;
      default: pinc = 32'hffff_ffff - $urandom_range(16);
    endcase
    case ($urandom_range(9))
      0:       clen = 24'd0;
      1:       clen = 24'($urandom);
      2:       clen = 24'hff_ffff;
      default: clen = 24'($urandom_range(1, 64));
    endcase
    if ($urandom_range(9) == 0) alen = 24'($urandom);
    else alen = 24'($urandom_range(0, int'(clen) + 4));
    aud = (alen < clen) ? alen : clen;
    if ($urandom_range(9) == 0) rlen = 23'($urandom);
    else rlen = 23'($urandom_range(0, int'(aud >> 1) + 2));
    case ($urandom_range(9))
      0:       rrec = $urandom;
      1:       rrec = 32'h8000_0000;
      2:       rrec = 32'd0;
      default: rrec = (rlen == 23'd0) ? 32'd0 : 32'h8000_0000 / 32'(rlen);
    endcase
    program_all(pinc, clen, alen, rlen, rrec, pick_q15(), pick_q15(), pick_q15());
  endtask

  initial begin
    int phase_no;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: free running, then a restart in the middle.
    drive_sample(1'b0);
    drive_sample(1'b0);
    drive_sample(1'b1);
    drive_sample(1'b0);
    in_tvalid <= 1'b0;
    wait_drained();

    // Zero-length cycle: silence while the carrier keeps turning.
    program_all(32'hffff_ffff, 24'd0, 24'd10200, 23'd2040, 32'd1052688,
                16'd16384, 16'd32768, 16'd32768);
    run_burst(2, 1'b0, 0);

    // Audible past the cycle end, ramp too long, reciprocal too large,
    // and every gain above one so that the outputs overshoot.
    program_all(32'h4000_0000, 24'd8, 24'd20, 23'd100, 32'hffff_ffff,
                16'hffff, 16'hffff, 16'hffff);
    run_burst(8, 1'b1, 0);

    // No ramp at all, a muted left channel and full-scale amplitude.
    program_all(32'h1234_5678, 24'd6, 24'd6, 23'd0, 32'd0,
                16'd32768, 16'd0, 16'd32768);
    run_burst(4, 1'b1, 0);

    // Shrink the cycle under the current position, which must wrap.
    program_all(32'h0800_0000, 24'd40, 24'd30, 23'd10, 32'h8000_0000 / 32'd10,
                16'd32768, 16'd32768, 16'd16384);
    run_burst(6, 1'b1, 0);
    write_reg(REG_CYCLE_LEN, 32'd3);
    cfg_valid <= 1'b0;
    run_burst(2, 1'b0, 0);

    // Random settings, one burst each; one burst runs without any stalls.
    phase_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      quiet = (phase_no == 4);
      randomize_config();
      run_burst($urandom_range(80, 140), 1'($urandom_range(1)), 3);
      phase_no++;
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
